>>> design/event_duration_timer_bank_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the event duration timer bank
// Concurrent checks clocked by clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef EVENT_DURATION_TIMER_BANK_CORE_MACROS_SVH
`define EVENT_DURATION_TIMER_BANK_CORE_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge out of reset.
`define EDTB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The condition must never be true at a clock edge out of reset.
`define EDTB_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define EDTB_ASSERT(lbl, prop, msg)
`define EDTB_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

>>> design/edtb_pkg.sv
// ----------------------------------------------------------------------------
// Event duration timer bank package
// Shared widths, command and operation codes, and the queue item type.
// ----------------------------------------------------------------------------
`default_nettype none

package edtb_pkg;

  localparam int CODE_W     = 16;
  localparam int DUR_W      = 16;
  localparam int TIME_W     = 32;
  localparam int COUNT_W    = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int BCOUNT_W   = 3;
  localparam int SPAN_W     = 22;   // a duration in minutes times sixty
  localparam int SEC_PER_MIN = 60;
  localparam int COUNT_MAX  = 31;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_EVENT_CODES   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DURATIONS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BINDING_COUNT = 2'd2;

  // Input commands
  localparam logic CMD_EVENT = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Operations handed from the front to the back
  localparam logic [1:0] OP_MISS  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  typedef struct packed {
    logic [1:0]        op;
    logic [TIME_W-1:0] tval;   // end time for a start, tick time for a tick
  } edtb_item_t;

endpackage

`default_nettype wire

>>> design/edtb_front.sv
// ----------------------------------------------------------------------------
// Event duration timer bank front end
// Holds the binding table, matches events and computes saturated end times.
// ----------------------------------------------------------------------------
`default_nettype none

module edtb_front #(
  parameter int BINDINGS = 4
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [edtb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [edtb_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire logic                               in_cmd,
  input  wire logic [edtb_pkg::CODE_W-1:0]        in_event_code,
  input  wire logic [edtb_pkg::TIME_W-1:0]        in_now_seconds,
  output edtb_pkg::edtb_item_t                    item
);

  logic [edtb_pkg::CFG_DATA_W-1:0] codes_r;
  logic [edtb_pkg::CFG_DATA_W-1:0] durs_r;
  logic [edtb_pkg::BCOUNT_W-1:0]   bcount_r;

  logic                          hit;
  logic [edtb_pkg::DUR_W-1:0]    dur;
  logic [edtb_pkg::SPAN_W-1:0]   span;
  logic [edtb_pkg::TIME_W:0]     sum;
  logic [edtb_pkg::TIME_W-1:0]   end_time;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codes_r  <= '0;
      durs_r   <= '0;
      bcount_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        edtb_pkg::CFG_EVENT_CODES:   codes_r  <= cfg_wdata;
        edtb_pkg::CFG_DURATIONS:     durs_r   <= cfg_wdata;
        edtb_pkg::CFG_BINDING_COUNT: bcount_r <= cfg_wdata[edtb_pkg::BCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // First binding in use whose code matches wins. A count above BINDINGS
  // needs no clamp since the loop stops at BINDINGS.
  always_comb begin
    hit = 1'b0;
    dur = '0;
    for (int i = 0; i < BINDINGS; i++) begin
      if (!hit && (edtb_pkg::BCOUNT_W'(i) < bcount_r) &&
          (codes_r[i*edtb_pkg::CODE_W +: edtb_pkg::CODE_W] == in_event_code)) begin
        hit = 1'b1;
        dur = durs_r[i*edtb_pkg::DUR_W +: edtb_pkg::DUR_W];
      end
    end
  end

  assign span = {{(edtb_pkg::SPAN_W-edtb_pkg::DUR_W){1'b0}}, dur} *
                edtb_pkg::SPAN_W'(edtb_pkg::SEC_PER_MIN);
  assign sum  = {1'b0, in_now_seconds} +
                {{(edtb_pkg::TIME_W+1-edtb_pkg::SPAN_W){1'b0}}, span};
  assign end_time = sum[edtb_pkg::TIME_W] ? '1 : sum[edtb_pkg::TIME_W-1:0];

  always_comb begin
    if (in_cmd == edtb_pkg::CMD_TICK) begin
      item.op   = edtb_pkg::OP_TICK;
      item.tval = in_now_seconds;
    end else if (hit) begin
      item.op   = edtb_pkg::OP_START;
      item.tval = end_time;
    end else begin
      item.op   = edtb_pkg::OP_MISS;
      item.tval = '0;
    end
  end

endmodule

`default_nettype wire

>>> design/edtb_queue.sv
// ----------------------------------------------------------------------------
// Event duration timer bank item queue
// A short FIFO of classified items between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "event_duration_timer_bank_core_macros.svh"

module edtb_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire edtb_pkg::edtb_item_t push_item,
  output logic                      full,
  input  wire logic                 pop,
  output logic                      not_empty,
  output edtb_pkg::edtb_item_t      head
);

  edtb_pkg::edtb_item_t             entry_r [edtb_pkg::QUEUE_DEPTH];
  logic [edtb_pkg::QPTR_W-1:0]      wr_ptr_r;
  logic [edtb_pkg::QPTR_W-1:0]      rd_ptr_r;
  logic [edtb_pkg::QPTR_W:0]        count_r;

  assign full      = (count_r == (edtb_pkg::QPTR_W+1)'(edtb_pkg::QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  `EDTB_ASSERT_NEVER(a_queue_overrun, push && full && !pop, "edtb: item pushed into a full queue")
  `EDTB_ASSERT_NEVER(a_queue_underrun, pop && !not_empty, "edtb: item popped from an empty queue")

endmodule

`default_nettype wire

>>> design/edtb_back.sv
// ----------------------------------------------------------------------------
// Event duration timer bank back end
// Keeps the pending intervals, applies starts and ticks, registers results.
// ----------------------------------------------------------------------------
`default_nettype none
`include "event_duration_timer_bank_core_macros.svh"

module edtb_back #(
  parameter int PENDING_DEPTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          q_not_empty,
  input  wire edtb_pkg::edtb_item_t          q_head,
  output logic                               pop,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_alarm_set,
  output logic [edtb_pkg::TIME_W-1:0]        out_alarm_time,
  output logic [edtb_pkg::COUNT_W-1:0]       out_active_count,
  output logic                               out_dropped
);

  localparam int SLOT_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int CNT_W  = $clog2(PENDING_DEPTH + 1);

  logic [PENDING_DEPTH-1:0]      valid_r;
  logic [PENDING_DEPTH-1:0]      valid_nxt;
  logic [edtb_pkg::TIME_W-1:0]   end_r [PENDING_DEPTH];
  logic [CNT_W-1:0]              active_r;
  logic [CNT_W-1:0]              active_nxt;

  logic                          out_valid_r;
  logic                          out_alarm_set_r;
  logic [edtb_pkg::TIME_W-1:0]   out_alarm_time_r;
  logic [edtb_pkg::COUNT_W-1:0]  out_active_count_r;
  logic                          out_dropped_r;

  logic                          free_found;
  logic [SLOT_W-1:0]             free_slot;
  logic [PENDING_DEPTH-1:0]      expired;
  logic [CNT_W-1:0]              n_expired;
  logic                          do_write;
  logic                          alarm_nxt;
  logic                          drop_nxt;
  logic [edtb_pkg::COUNT_W-1:0]  count_nxt;

  assign pop = q_not_empty && (!out_valid_r || !out_stall);

  // Lowest free slot and the set of entries that a tick would retire.
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    n_expired  = '0;
    for (int i = 0; i < PENDING_DEPTH; i++) begin
      expired[i] = valid_r[i] && (end_r[i] <= q_head.tval);
      n_expired  = n_expired + CNT_W'(expired[i]);
      if (!valid_r[i] && !free_found) begin
        free_found = 1'b1;
        free_slot  = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    valid_nxt  = valid_r;
    active_nxt = active_r;
    do_write   = 1'b0;
    alarm_nxt  = 1'b0;
    drop_nxt   = 1'b0;
    unique case (q_head.op)
      edtb_pkg::OP_START: begin
        if (free_found) begin
          do_write             = 1'b1;
          alarm_nxt            = 1'b1;
          valid_nxt[free_slot] = 1'b1;
          active_nxt           = active_r + 1'b1;
        end else begin
          drop_nxt = 1'b1;
        end
      end
      edtb_pkg::OP_TICK: begin
        valid_nxt  = valid_r & ~expired;
        active_nxt = active_r - n_expired;
      end
      default: ;
    endcase
  end

  // The reported count saturates when the store can hold more than it shows.
  assign count_nxt = (active_nxt > CNT_W'(edtb_pkg::COUNT_MAX)) ?
                     edtb_pkg::COUNT_W'(edtb_pkg::COUNT_MAX) :
                     edtb_pkg::COUNT_W'(active_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      active_r <= '0;
    end else if (pop) begin
      valid_r  <= valid_nxt;
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && do_write) begin
      end_r[free_slot] <= q_head.tval;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_alarm_set_r    <= alarm_nxt;
      out_alarm_time_r   <= alarm_nxt ? q_head.tval : '0;
      out_active_count_r <= count_nxt;
      out_dropped_r      <= drop_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_alarm_set    = out_alarm_set_r;
  assign out_alarm_time   = out_alarm_time_r;
  assign out_active_count = out_active_count_r;
  assign out_dropped      = out_dropped_r;

  `EDTB_ASSERT(a_count_tracks_valid, active_r == $countones(valid_r), "edtb: active count differs from valid entries")
  `EDTB_ASSERT(a_start_raises_alarm, (pop && q_head.op == edtb_pkg::OP_START && free_found) |=> (out_valid_r && out_alarm_set_r), "edtb: start with a free slot gave no alarm")
  `EDTB_ASSERT_NEVER(a_alarm_and_drop, out_valid_r && out_alarm_set_r && out_dropped_r, "edtb: result both set an alarm and dropped")

endmodule

`default_nettype wire

>>> design/event_duration_timer_bank_core.sv
// ----------------------------------------------------------------------------
// Event duration timer bank
// Events and ticks enter on the in_ channel, each carrying the current time
// in seconds, and every item yields exactly one result on the out_ channel.
// The front end matches an event against the binding table and computes its
// saturated end time in the cycle the item is taken; a two-item queue hands
// it to the back end, which updates the pending store (one comparator per
// entry, so a tick retires all due intervals at once) and loads the output
// register. Sustained rate is one item per cycle while out_stall is low; an
// accepted item is written into the queue, and its result is loaded into the
// output register when the back end pops it, and the queue keeps the input
// open for two more items while a result waits. The pending store needs no
// clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module event_duration_timer_bank_core #(
  parameter int BINDINGS      = 4,
  parameter int PENDING_DEPTH = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [edtb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [edtb_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            in_cmd,
  input  wire logic [edtb_pkg::CODE_W-1:0]     in_event_code,
  input  wire logic [edtb_pkg::TIME_W-1:0]     in_now_seconds,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_alarm_set,
  output logic [edtb_pkg::TIME_W-1:0]          out_alarm_time,
  output logic [edtb_pkg::COUNT_W-1:0]         out_active_count,
  output logic                                 out_dropped
);

  edtb_pkg::edtb_item_t front_item;
  edtb_pkg::edtb_item_t q_head;
  logic                 q_full;
  logic                 q_not_empty;
  logic                 q_pop;
  logic                 q_push;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  edtb_front #(
    .BINDINGS (BINDINGS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_cmd         (in_cmd),
    .in_event_code  (in_event_code),
    .in_now_seconds (in_now_seconds),
    .item           (front_item)
  );

  edtb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  edtb_back #(
    .PENDING_DEPTH (PENDING_DEPTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_not_empty      (q_not_empty),
    .q_head           (q_head),
    .pop              (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_alarm_set    (out_alarm_set),
    .out_alarm_time   (out_alarm_time),
    .out_active_count (out_active_count),
    .out_dropped      (out_dropped)
  );

endmodule

`default_nettype wire
